FILE: rtl/core/aaba_pkg.sv
// Shared types and constants for the backward-acceptance unit of an
// alternating automaton. Used by the top level and the checker.
// No dependencies.
`default_nettype none

package aaba_pkg;

    localparam int NUM_STATES      = 16;
    localparam int MAX_TRANS_DEF   = 64;

    localparam int CMD_W    = 2;
    localparam int STATE_W  = 4;
    localparam int LETTER_W = 8;
    localparam int MASK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // States at or above NUM_STATES never show up in any set.
    localparam logic [MASK_W-1:0] STATE_MASK =
        (NUM_STATES >= MASK_W) ? {MASK_W{1'b1}} :
        MASK_W'((64'd1 << NUM_STATES) - 64'd1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_DUP   = 2'd2,
        STS_FULL  = 2'd3
    } t_status;

    // Register index, taken from bit 2 of the byte address.
    localparam logic REG_FINAL_MASK = 1'b0;

    typedef struct packed {
        logic [STATE_W-1:0]  src;
        logic [LETTER_W-1:0] lab;
        logic [MASK_W-1:0]   tgt;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

FILE: rtl/core/aaba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module aaba_ram #(
    parameter int WIDTH  = 28,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/alternating_automaton_backward_accept_unit.sv
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  item    | in        | i_valid / o_stall  | i_cmd i_src_state i_letter i_target_mask
//          |           |                    | i_query_state
//  result  | out       | o_valid / i_stall  | o_status o_accepted o_state_set
//  config  | in        | APB (psel..pready) | final_mask at byte address 0
//
// Start, query and empty-mask add items go straight to the output stage. Add items
// with a non-empty mask and letter items scan the transition RAM, one entry per
// cycle through its single read port.
// A finished item waits in the output stage for as long as an earlier result is
// stalled.
// Reset is synchronous and active low; the table contents are not cleared, only
// the fill count, so no clearing pass is needed.
// A result waits in the output register while the next item is accepted; the
// unit stalls its input only while an item is in flight or reset is asserted.
//
// Depends on aaba_pkg and aaba_ram.
`default_nettype none

module alternating_automaton_backward_accept_unit #(
    parameter int MAX_TRANS = aaba_pkg::MAX_TRANS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [aaba_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [aaba_pkg::STATE_W-1:0]  i_src_state,
    input  wire logic [aaba_pkg::LETTER_W-1:0] i_letter,
    input  wire logic [aaba_pkg::MASK_W-1:0]   i_target_mask,
    input  wire logic [aaba_pkg::STATE_W-1:0]  i_query_state,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [aaba_pkg::STATUS_W-1:0]      o_status,
    output logic                               o_accepted,
    output logic [aaba_pkg::MASK_W-1:0]        o_state_set,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aaba_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [aaba_pkg::DATA_W-1:0]   pwdata,
    output logic [aaba_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import aaba_pkg::*;

    localparam int AW = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
    localparam int CW = $clog2(MAX_TRANS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    t_entry              r_item;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic                r_cmp_vld;
    logic                r_dup;
    logic [MASK_W-1:0]   r_acc;
    logic [MASK_W-1:0]   r_set;
    logic [MASK_W-1:0]   r_final_mask;
    t_status             r_res_status;
    logic                r_res_accepted;
    logic                r_out_valid;
    t_status             r_out_status;
    logic                r_out_accepted;
    logic [MASK_W-1:0]   r_out_set;

    logic                in_accept;
    logic                cfg_write;
    logic                rd_issue;
    logic                scan_done;
    logic                out_free;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    logic [MASK_W-1:0]   tgt_masked;
    logic                hit_dup;
    logic                hit_step;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_FINAL_MASK) ? DATA_W'(r_final_mask) : '0;
    assign cfg_write = psel & penable & pwrite & pready;

    assign o_stall     = (r_state != S_IDLE) | ~i_rst_n;
    assign in_accept   = i_valid & ~o_stall;
    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_accepted  = r_out_accepted;
    assign o_state_set = r_out_set;
    assign out_free    = ~r_out_valid | ~i_stall;

    assign tgt_masked = i_target_mask & STATE_MASK;

    // The table is only written at the end of a scan, after its last read has
    // returned, so reads and writes to the same entry never overlap.
    assign rd_issue  = (r_state == S_SCAN) && (r_idx < r_count);
    assign scan_done = (r_state == S_SCAN) && !rd_issue && !r_cmp_vld;
    assign ram_we    = scan_done && (r_cmd == CMD_ADD) && !r_dup &&
                       (r_count < CW'(MAX_TRANS));

    assign rd_entry = t_entry'(ram_rdata);
    assign hit_dup  = r_cmp_vld && (rd_entry == r_item);
    assign hit_step = r_cmp_vld && (rd_entry.lab == r_item.lab) &&
                      ((rd_entry.tgt & ~r_set) == '0);

    aaba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRANS),
        .ADDR_W(AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_item),
        .i_re   (rd_issue),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_set        <= '0;
            r_final_mask <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_FINAL_MASK) begin
                r_final_mask <= pwdata[MASK_W-1:0];
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd          <= t_cmd'(i_cmd);
                        r_item         <= '{src: i_src_state, lab: i_letter,
                                            tgt: tgt_masked};
                        r_res_status   <= (t_cmd'(i_cmd) == CMD_ADD && tgt_masked == '0) ?
                                          STS_EMPTY : STS_OK;
                        r_res_accepted <= (t_cmd'(i_cmd) == CMD_QUERY) &&
                                          r_set[i_query_state];
                        r_idx          <= '0;
                        r_cmp_vld      <= 1'b0;
                        r_dup          <= 1'b0;
                        r_acc          <= '0;
                        case (t_cmd'(i_cmd))
                            CMD_ADD: begin
                                if (tgt_masked == '0) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_START: begin
                                r_set   <= r_final_mask & STATE_MASK;
                                r_state <= S_OUT;
                            end
                            CMD_STEP: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= rd_issue;
                    if (rd_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (hit_dup) begin
                        r_dup <= 1'b1;
                    end
                    if (hit_step) begin
                        r_acc <= r_acc | (MASK_W'(1) << rd_entry.src);
                    end
                    if (scan_done) begin
                        if (r_cmd == CMD_ADD) begin
                            if (r_dup) begin
                                r_res_status <= STS_DUP;
                            end else if (r_count >= CW'(MAX_TRANS)) begin
                                r_res_status <= STS_FULL;
                            end else begin
                                r_count <= r_count + CW'(1);
                            end
                        end else begin
                            r_set <= r_acc & STATE_MASK;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_status   <= r_res_status;
                        r_out_accepted <= r_res_accepted;
                        r_out_set      <= r_set;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/aaba_checker.sv
// Port-level checks for the backward-acceptance unit, bound to its top level.
// Depends on aaba_pkg.
`default_nettype none

module aaba_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [aaba_pkg::STATUS_W-1:0] o_status,
    input wire logic                          o_accepted,
    input wire logic [aaba_pkg::MASK_W-1:0]   o_state_set
);
    import aaba_pkg::*;

    // A result beat that is held back keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) &&
                               $stable(o_accepted) && $stable(o_state_set))
        else $error("held result beat changed");

    // Only one item is in flight: the input stalls right after a beat is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item accepted while one is in flight");

    // A positive query answer carries the OK status, and a positive answer
    // comes only from a non-empty set.
    a_acc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_status == STS_OK && o_state_set != '0)
        else $error("query answer inconsistent with status or set");

    // The reported set never holds states outside the automaton.
    a_set_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_state_set & ~STATE_MASK) == '0)
        else $error("state set holds an out-of-range state");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

endmodule

bind alternating_automaton_backward_accept_unit aaba_checker u_aaba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_accepted (o_accepted),
    .o_state_set(o_state_set)
);

`default_nettype wire
